>>> rtl/core/sirds_scanline_linker_assert.svh
// Assertion macros for the scanline linker checks.
// All checks sample on the rising edge of i_clk.
`ifndef SIRDS_SCANLINE_LINKER_ASSERT_SVH
`define SIRDS_SCANLINE_LINKER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define SIRDS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sirds check failed");

// Next-cycle implication, off during reset.
`define SIRDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sirds check failed");

// Next-cycle implication that also holds through reset.
`define SIRDS_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("sirds check failed");

`endif

>>> rtl/core/sirds_pkg.sv
// ----------------------------------------------------------------------------
// sirds_pkg
// Shared sizes, codes and beat types of the stereogram scanline linker.
// ----------------------------------------------------------------------------
package sirds_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int OVERSAMPLE = 4;
    localparam int VMAX       = MAX_WIDTH * OVERSAMPLE;

    localparam int VX_W  = $clog2(VMAX);
    localparam int POS_W = $clog2(VMAX + 1);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int DA_W  = $clog2(MAX_WIDTH);
    localparam int K_W   = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;

    localparam int DEPTH_NUM_OFS = 510;
    localparam int DEPTH_DEN_OFS = 1275;

    localparam int E_MAX   = (255 * 5) / 2;
    localparam int VE_MAX  = E_MAX * OVERSAMPLE;
    localparam int VE_W    = $clog2(VE_MAX + 1);
    localparam int NUM_MAX = VE_MAX * (DEPTH_NUM_OFS + 255);
    localparam int NUM_W   = $clog2(NUM_MAX + 1);
    localparam int DEN_W   = $clog2(DEPTH_DEN_OFS + 255 + 1);
    localparam int S_W     = $clog2(VE_MAX / 2 + 1);
    localparam int AW      = ((POS_W > S_W) ? POS_W : S_W) + 2;
    localparam int SUM_W   = $clog2(255 * OVERSAMPLE + 1);
    localparam int DCNT_W  = $clog2(NUM_W + 1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_SEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STYLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 3'd3;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic [1:0] CS_BW    = 2'd0;
    localparam logic [1:0] CS_GREY  = 2'd1;
    localparam logic [1:0] CS_COLOR = 2'd2;

    typedef struct packed {
        logic       action;
        logic [7:0] depth;
        logic       row_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_last;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic       start;
        logic [1:0] style;
    } t_rng_req;

endpackage

>>> rtl/core/sirds_div.sv
// ----------------------------------------------------------------------------
// sirds_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sirds_div import sirds_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic [NUM_W-1:0] o_quot,
    output logic             o_done
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_den;

    logic [DEN_W:0] cur;
    logic [DEN_W:0] trial;
    logic           ge;

    always_comb begin
        cur   = {r_rem, r_q[NUM_W-1]};
        ge    = cur >= {1'b0, r_den};
        trial = cur - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DCNT_W'(1);
                if (r_cnt == DCNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? trial[DEN_W-1:0] : cur[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

>>> rtl/core/sirds_rng.sv
// ----------------------------------------------------------------------------
// sirds_rng
// Galois LFSR colour source: one draw per cycle, three draws for full colour.
// ----------------------------------------------------------------------------
module sirds_rng import sirds_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_load,
    input  logic [31:0] i_seed,
    input  t_rng_req    i_req,
    output logic [23:0] o_color,
    output logic        o_done
);

    localparam logic [31:0] LFSR_MASK = 32'hA3000000;

    function automatic logic [7:0] mod255(input logic [31:0] v);
        logic [9:0] s;
        logic [8:0] f;
        s = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[31:24]);
        f = 9'(s[7:0]) + 9'(s[9:8]);
        if (f >= 9'd255) begin
            f = f - 9'd255;
        end
        return f[7:0];
    endfunction

    logic [31:0] r_lfsr;
    logic        r_busy;
    logic [1:0]  r_cnt;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [23:0] r_color;
    logic        r_done;

    logic [31:0] n_lfsr;
    logic [7:0]  m;
    logic        active;

    always_comb begin
        n_lfsr = {1'b0, r_lfsr[31:1]};
        if (r_lfsr[0]) begin
            n_lfsr = n_lfsr ^ LFSR_MASK;
        end
        m      = mod255(n_lfsr);
        active = i_req.start | r_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= 32'd1;
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_seed_load) begin
                r_lfsr <= (i_seed == '0) ? 32'd1 : i_seed;
            end else if (active) begin
                r_lfsr <= n_lfsr;
                if (i_req.style == CS_COLOR && r_cnt != 2'd2) begin
                    r_busy <= 1'b1;
                    r_cnt  <= r_cnt + 2'd1;
                end else begin
                    r_busy <= 1'b0;
                    r_cnt  <= '0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (active) begin
            case (i_req.style)
                CS_GREY:  r_color <= {m, m, m};
                CS_COLOR: begin
                    if (r_cnt == 2'd0) begin
                        r_red <= m;
                    end else if (r_cnt == 2'd1) begin
                        r_green <= m;
                    end else begin
                        r_color <= {r_red, r_green, m};
                    end
                end
                default:  r_color <= {24{n_lfsr[0]}};
            endcase
        end
    end

    assign o_color = r_color;
    assign o_done  = r_done;

endmodule

>>> rtl/core/sirds_scanline_linker.sv
// ----------------------------------------------------------------------------
// sirds_scanline_linker
// Random-dot stereogram scanline generator with oversampled pixel linking.
// Input beats (i_in_valid / o_in_stall) carry a load or a drain action. A load
// stores one depth sample if it falls within the row width; a load with
// row_end then runs the row: fill (a fresh colour and self-links for every
// virtual pixel), link (a multiply and a divide in the shared divider per
// real pixel, then the link updates per virtual pixel) and colour (each
// virtual pixel copies its linked colour or draws a new one). A drain reads
// OVERSAMPLE colours and divides the three sums by OVERSAMPLE with a shift,
// then gives one result beat on o_out_valid / i_out_stall. Drains with no
// row pending give no beat. o_in_stall is high while a row or drain is at
// work, and also while a finished pixel waits for a stalled output register.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) are meant
// for idle time; writing the seed reloads the generator. Reset clears control
// state and restores the default registers; no clearing pass is needed since
// the link tables are rewritten at the start of every row.
// ----------------------------------------------------------------------------
module sirds_scanline_linker import sirds_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_FILL    = 21'h000002,
        S_FILL_W  = 21'h000004,
        S_LINK_D  = 21'h000008,
        S_LINK_M  = 21'h000010,
        S_LINK_V  = 21'h000020,
        S_LINK_DW = 21'h000040,
        S_LINK_P  = 21'h000080,
        S_LINK_R  = 21'h000100,
        S_LINK_B  = 21'h000200,
        S_LINK_F  = 21'h000400,
        S_LINK_N  = 21'h000800,
        S_C_RD    = 21'h001000,
        S_C_P     = 21'h002000,
        S_C_RNG   = 21'h004000,
        S_C_CP    = 21'h008000,
        S_C_N     = 21'h010000,
        S_D_RD    = 21'h020000,
        S_D_ACC   = 21'h040000,
        S_D_DIV   = 21'h080000,
        S_D_OUT   = 21'h100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [10:0] r_row_width;
    logic [7:0]  r_eye;
    logic [1:0]  r_style;

    // row bookkeeping
    logic [W_W-1:0]   r_load_pos;
    logic [W_W-1:0]   r_drain_pos;
    logic [W_W-1:0]   r_done_w;
    logic             r_drain_valid;
    logic             r_odd;
    logic [POS_W-1:0] r_vw;
    logic [VE_W-1:0]  r_ve;
    logic [VX_W-1:0]  r_center;

    // working registers
    logic [VX_W-1:0]  r_x;
    logic [K_W-1:0]   r_k;
    logic [DA_W-1:0]  r_ridx;
    logic [S_W-1:0]   r_s;
    logic [NUM_W-1:0] r_prod;
    logic [DEN_W-1:0] r_den;
    logic [VX_W-1:0]  r_left;
    logic [VX_W-1:0]  r_right;
    logic [VX_W-1:0]  r_pr;
    logic             r_vis;
    logic             r_dir_right;
    logic [SUM_W-1:0] r_sum [3];
    logic [7:0]       r_avg [3];
    t_out_item        r_out;
    logic             r_out_valid;

    // memories
    logic [7:0]      m_depth [MAX_WIDTH];
    logic [VX_W-1:0] m_ll    [VMAX];
    logic [VX_W-1:0] m_lr    [VMAX];
    logic [23:0]     m_col   [VMAX];

    logic            dm_we;
    logic [DA_W-1:0] dm_wa, dm_ra;
    logic [7:0]      r_dm_rd;
    logic            ll_we, lr_we, col_we;
    logic [VX_W-1:0] ll_wa, ll_wd, ll_ra, lr_wa, lr_wd, lr_ra, col_wa, col_ra;
    logic [23:0]     col_wd;
    logic [VX_W-1:0] r_ll_rd, r_lr_rd;
    logic [23:0]     r_col_rd;

    // shared units
    t_div_req         div_req;
    logic [NUM_W-1:0] div_quot;
    logic             div_done;
    t_rng_req         rng_req;
    logic [23:0]      rng_color;
    logic             rng_done;
    logic             seed_load;

    // derived values
    logic             in_acc;
    logic [31:0]      w32, e32, ve32, msep32, vw32, ctr32, base32;
    logic [W_W-1:0]   eff_w;
    logic [AW-1:0]    s_ext, half, left_u, right_u;
    logic             in_range;
    logic [POS_W-1:0] vw_m1;
    logic             x_last;
    logic [VX_W-1:0]  p_sel;
    logic [9:0]       dd;
    logic [VE_W+9:0]  prod_full;
    logic             out_free;
    logic             last_px;

    always_comb begin
        w32 = 32'(r_row_width);
        if (w32 == 32'd0) begin
            w32 = 32'd1;
        end else if (w32 > 32'(MAX_WIDTH)) begin
            w32 = 32'(MAX_WIDTH);
        end
        eff_w  = w32[W_W-1:0];
        e32    = (32'(r_eye) * 32'd5) >> 1;
        ve32   = e32 * 32'(OVERSAMPLE);
        msep32 = (e32 >> 1) * 32'(OVERSAMPLE);
        vw32   = w32 * 32'(OVERSAMPLE);
        ctr32  = (vw32 > msep32) ? ((vw32 - msep32) >> 1) : 32'd0;
        base32 = 32'(r_drain_pos) * 32'(OVERSAMPLE);

        s_ext    = AW'(r_s);
        half     = (s_ext + AW'(r_odd & r_s[0])) >> 1;
        left_u   = AW'(r_x) - half;
        right_u  = left_u + s_ext;
        in_range = !left_u[AW-1] && (right_u < AW'(r_vw));

        vw_m1  = r_vw - POS_W'(1);
        x_last = (r_x == vw_m1[VX_W-1:0]);
        p_sel  = r_dir_right ? r_ll_rd : r_lr_rd;

        dd        = 10'(r_dm_rd) + 10'(DEPTH_NUM_OFS);
        prod_full = (VE_W + 10)'(r_ve) * (VE_W + 10)'(dd);

        out_free = !r_out_valid || !i_out_stall;
        last_px  = ((W_W + 1)'(r_drain_pos) + (W_W + 1)'(1)) == (W_W + 1)'(r_done_w);
        in_acc   = i_in_valid && (r_state == S_IDLE);
    end

    // sequencer and memory port control
    always_comb begin
        n_state = r_state;
        dm_we   = 1'b0;
        dm_wa   = r_load_pos[DA_W-1:0];
        dm_ra   = r_ridx;
        ll_we   = 1'b0;
        ll_wa   = r_x;
        ll_wd   = r_x;
        ll_ra   = r_x;
        lr_we   = 1'b0;
        lr_wa   = r_x;
        lr_wd   = r_x;
        lr_ra   = r_x;
        col_we  = 1'b0;
        col_wa  = r_x;
        col_wd  = rng_color;
        col_ra  = r_x;
        div_req.start = 1'b0;
        div_req.num   = r_prod;
        div_req.den   = r_den;
        rng_req.start = 1'b0;
        rng_req.style = r_style;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.action == ACT_LOAD) begin
                        dm_we = (r_load_pos < eff_w);
                        if (i_in_data.row_end) begin
                            n_state = S_FILL;
                        end
                    end else if (r_drain_valid && (r_drain_pos < r_done_w)) begin
                        n_state = S_D_RD;
                    end
                end
            end
            S_FILL: begin
                rng_req.start = 1'b1;
                n_state = S_FILL_W;
            end
            S_FILL_W: begin
                if (rng_done) begin
                    ll_we  = 1'b1;
                    lr_we  = 1'b1;
                    col_we = 1'b1;
                    n_state = x_last ? S_LINK_D : S_FILL;
                end
            end
            S_LINK_D:  n_state = S_LINK_M;
            S_LINK_M:  n_state = S_LINK_V;
            S_LINK_V: begin
                div_req.start = 1'b1;
                n_state = S_LINK_DW;
            end
            S_LINK_DW: begin
                if (div_done) begin
                    n_state = S_LINK_P;
                end
            end
            S_LINK_P: begin
                ll_ra = right_u[VX_W-1:0];
                lr_ra = left_u[VX_W-1:0];
                n_state = in_range ? S_LINK_R : S_LINK_N;
            end
            S_LINK_R: begin
                // drop the partner's older, longer link
                if (r_ll_rd != r_right && r_ll_rd < r_left) begin
                    lr_we = 1'b1;
                    lr_wa = r_ll_rd;
                    lr_wd = r_ll_rd;
                    ll_we = 1'b1;
                    ll_wa = r_right;
                    ll_wd = r_right;
                end
                n_state = S_LINK_B;
            end
            S_LINK_B: begin
                if (r_pr != r_left && r_pr > r_right) begin
                    ll_we = 1'b1;
                    ll_wa = r_pr;
                    ll_wd = r_pr;
                    lr_we = 1'b1;
                    lr_wa = r_left;
                    lr_wd = r_left;
                end
                n_state = S_LINK_F;
            end
            S_LINK_F: begin
                if (r_vis) begin
                    ll_we = 1'b1;
                    ll_wa = r_right;
                    ll_wd = r_left;
                    lr_we = 1'b1;
                    lr_wa = r_left;
                    lr_wd = r_right;
                end
                n_state = S_LINK_N;
            end
            S_LINK_N: begin
                if (x_last) begin
                    n_state = S_C_RD;
                end else if (r_k == K_W'(OVERSAMPLE - 1)) begin
                    n_state = S_LINK_D;
                end else begin
                    n_state = S_LINK_P;
                end
            end
            S_C_RD:    n_state = S_C_P;
            S_C_P: begin
                col_ra = p_sel;
                if (p_sel == r_x) begin
                    rng_req.start = 1'b1;
                    n_state = S_C_RNG;
                end else begin
                    n_state = S_C_CP;
                end
            end
            S_C_RNG: begin
                if (rng_done) begin
                    col_we = 1'b1;
                    n_state = S_C_N;
                end
            end
            S_C_CP: begin
                col_we = 1'b1;
                col_wd = r_col_rd;
                n_state = S_C_N;
            end
            S_C_N: begin
                if (r_dir_right && x_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_C_RD;
                end
            end
            S_D_RD:    n_state = S_D_ACC;
            S_D_ACC: begin
                n_state = (r_k == K_W'(OVERSAMPLE - 1)) ? S_D_DIV : S_D_RD;
            end
            S_D_DIV:   n_state = S_D_OUT;
            S_D_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_row_width   <= 11'd640;
            r_eye         <= 8'd90;
            r_style       <= CS_BW;
            r_load_pos    <= '0;
            r_drain_pos   <= '0;
            r_done_w      <= '0;
            r_drain_valid <= 1'b0;
            r_odd         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ROW_WIDTH: r_row_width <= i_cfg_data[10:0];
                    CFG_EYE_SEP:   r_eye       <= i_cfg_data[7:0];
                    CFG_STYLE:     r_style     <= i_cfg_data[1:0];
                    default:       ;
                endcase
            end
            if (in_acc && i_in_data.action == ACT_LOAD) begin
                if (i_in_data.row_end) begin
                    r_load_pos    <= '0;
                    r_drain_pos   <= '0;
                    r_done_w      <= eff_w;
                    r_drain_valid <= 1'b1;
                end else if (r_load_pos < eff_w) begin
                    r_load_pos <= r_load_pos + W_W'(1);
                end
            end
            if (r_state == S_C_N && r_dir_right && x_last) begin
                r_odd <= ~r_odd;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_D_OUT && out_free) begin
                r_out_valid <= 1'b1;
                r_drain_pos <= r_drain_pos + W_W'(1);
                if (last_px) begin
                    r_drain_valid <= 1'b0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // a row starts its fill at zero, a drain at its pixel
                r_x   <= (i_in_data.action == ACT_DRAIN) ? base32[VX_W-1:0] : '0;
                r_k   <= '0;
                r_sum <= '{default: '0};
                r_vw     <= vw32[POS_W-1:0];
                r_ve     <= ve32[VE_W-1:0];
                r_center <= ctr32[VX_W-1:0];
            end
            S_FILL_W: begin
                if (rng_done) begin
                    if (x_last) begin
                        r_x    <= '0;
                        r_k    <= '0;
                        r_ridx <= '0;
                    end else begin
                        r_x <= r_x + VX_W'(1);
                    end
                end
            end
            S_LINK_M: begin
                r_prod <= prod_full[NUM_W-1:0];
                r_den  <= DEN_W'(r_dm_rd) + DEN_W'(DEPTH_DEN_OFS);
            end
            S_LINK_DW: begin
                if (div_done) begin
                    r_s <= div_quot[S_W-1:0];
                end
            end
            S_LINK_P: begin
                r_left  <= left_u[VX_W-1:0];
                r_right <= right_u[VX_W-1:0];
            end
            S_LINK_R: begin
                r_pr  <= r_lr_rd;
                r_vis <= !(r_ll_rd != r_right && !(r_ll_rd < r_left));
            end
            S_LINK_B: begin
                if (r_pr != r_left && !(r_pr > r_right)) begin
                    r_vis <= 1'b0;
                end
            end
            S_LINK_N: begin
                if (x_last) begin
                    // colour outward: left half downward, then right half upward
                    if (r_center != '0) begin
                        r_x         <= r_center - VX_W'(1);
                        r_dir_right <= 1'b0;
                    end else begin
                        r_x         <= r_center;
                        r_dir_right <= 1'b1;
                    end
                end else begin
                    r_x <= r_x + VX_W'(1);
                    if (r_k == K_W'(OVERSAMPLE - 1)) begin
                        r_k    <= '0;
                        r_ridx <= r_ridx + DA_W'(1);
                    end else begin
                        r_k <= r_k + K_W'(1);
                    end
                end
            end
            S_C_N: begin
                if (!r_dir_right) begin
                    if (r_x == '0) begin
                        r_x         <= r_center;
                        r_dir_right <= 1'b1;
                    end else begin
                        r_x <= r_x - VX_W'(1);
                    end
                end else if (!x_last) begin
                    r_x <= r_x + VX_W'(1);
                end
            end
            S_D_ACC: begin
                r_sum[0] <= r_sum[0] + SUM_W'(r_col_rd[23:16]);
                r_sum[1] <= r_sum[1] + SUM_W'(r_col_rd[15:8]);
                r_sum[2] <= r_sum[2] + SUM_W'(r_col_rd[7:0]);
                r_x <= r_x + VX_W'(1);
                r_k <= r_k + K_W'(1);
            end
            S_D_DIV: begin
                r_avg[0] <= 8'(r_sum[0] / SUM_W'(OVERSAMPLE));
                r_avg[1] <= 8'(r_sum[1] / SUM_W'(OVERSAMPLE));
                r_avg[2] <= 8'(r_sum[2] / SUM_W'(OVERSAMPLE));
            end
            S_D_OUT: begin
                if (out_free) begin
                    r_out.red      <= r_avg[0];
                    r_out.green    <= r_avg[1];
                    r_out.blue     <= r_avg[2];
                    r_out.row_last <= last_px;
                end
            end
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            m_depth[dm_wa] <= i_in_data.depth;
        end
        r_dm_rd <= m_depth[dm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ll_we) begin
            m_ll[ll_wa] <= ll_wd;
        end
        r_ll_rd <= m_ll[ll_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lr_we) begin
            m_lr[lr_wa] <= lr_wd;
        end
        r_lr_rd <= m_lr[lr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            m_col[col_wa] <= col_wd;
        end
        r_col_rd <= m_col[col_ra];
    end

    assign seed_load = i_cfg_valid && (i_cfg_index == CFG_SEED);

    sirds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_quot  (div_quot),
        .o_done  (div_done)
    );

    sirds_rng u_rng (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed_load (seed_load),
        .i_seed      (i_cfg_data),
        .i_req       (rng_req),
        .o_color     (rng_color),
        .o_done      (rng_done)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

>>> rtl/core/sirds_checker.sv
// ----------------------------------------------------------------------------
// sirds_checker
// Port-level checks of the scanline linker, bound to the top level.
// ----------------------------------------------------------------------------
`include "sirds_scanline_linker_assert.svh"

module sirds_checker import sirds_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input t_in_item             i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_item            o_out_data,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [31:0]          i_cfg_data
);

    logic row_end_beat;
    assign row_end_beat = i_in_valid && !o_in_stall
                          && (i_in_data.action == ACT_LOAD) && i_in_data.row_end;

    `SIRDS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `SIRDS_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data))
    `SIRDS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid)
    `SIRDS_ASSERT_SAME(a_beat_from_work, $rose(o_out_valid), $past(o_in_stall))
    `SIRDS_ASSERT_NEXT(a_row_busy, row_end_beat, o_in_stall)

endmodule

bind sirds_scanline_linker sirds_checker u_sirds_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereogram scanline linker. Depth rows are
// loaded, processed and drained under random input gaps and output stalls;
// every drained pixel is compared against a behavioral predictor that tracks
// links, the colour generator and the oversampled averages.
// ----------------------------------------------------------------------------
module tb;
    import sirds_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int SETTLE       = 300;
    localparam int N_ITEMS      = 1750;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    sirds_scanline_linker DUT (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [10:0] row_width_q;
    logic [7:0]  eye_sep_q;
    logic [1:0]  style_q;
    logic [31:0] lfsr_q;
    logic [7:0]  depth_mem [MAX_WIDTH];
    int          left_of [VMAX];
    int          right_of [VMAX];
    logic [23:0] vcolor [VMAX];
    bit          odd_row;
    int          load_pos, drain_pos, done_w;
    bit          drain_ok;
    int          written_cnt;

    t_in_item  pending_beats[$];
    t_out_item expected_pixels[$];

    int  idle_mode = 0;
    int  accepted = 0, generated = 0, pixels_seen = 0, rows_run = 0;
    int  mismatches = 0;
    longint cycles = 0;

    function automatic int width_eff();
        if (row_width_q < 1) return 1;
        if (row_width_q > MAX_WIDTH) return MAX_WIDTH;
        return int'(row_width_q);
    endfunction

    function automatic logic [31:0] lfsr_draw();
        bit lsb;
        lsb = lfsr_q[0];
        lfsr_q = lfsr_q >> 1;
        if (lsb) lfsr_q ^= 32'hA300_0000;
        return lfsr_q;
    endfunction

    function automatic logic [23:0] random_color();
        logic [7:0] r, g, b;
        if (style_q == CS_GREY) begin
            r = 8'(lfsr_draw() % 255);
            return {r, r, r};
        end
        if (style_q == CS_COLOR) begin
            r = 8'(lfsr_draw() % 255);
            g = 8'(lfsr_draw() % 255);
            b = 8'(lfsr_draw() % 255);
            return {r, g, b};
        end
        r = lfsr_draw() & 1 ? 8'd255 : 8'd0;
        return {r, r, r};
    endfunction

    function automatic void link_row(int w);
        int vw, e, ve, msep, center, s, x, d, lft, rgt, pl, pr;
        bit vis;
        vw = w * OVERSAMPLE;
        e = (eye_sep_q * 5) / 2;
        ve = e * OVERSAMPLE;
        msep = (e / 2) * OVERSAMPLE;
        center = vw > msep ? (vw - msep) / 2 : 0;
        s = 0;
        for (x = 0; x < vw; x++) begin
            left_of[x] = x;
            right_of[x] = x;
            vcolor[x] = random_color();
        end
        for (x = 0; x < vw; x++) begin
            vis = 1;
            if (x % OVERSAMPLE == 0) begin
                d = depth_mem[x / OVERSAMPLE];
                s = (ve * (510 + d)) / (1275 + d);
            end
            lft = x - (s + (odd_row ? (s & 1) : 0)) / 2;
            rgt = lft + s;
            if (lft >= 0 && rgt < vw) begin
                pl = left_of[rgt];
                if (pl != rgt) begin
                    if (pl < lft) begin
                        right_of[pl] = pl;
                        left_of[rgt] = rgt;
                    end else vis = 0;
                end
                pr = right_of[lft];
                if (pr != lft) begin
                    if (pr > rgt) begin
                        left_of[pr] = pr;
                        right_of[lft] = lft;
                    end else vis = 0;
                end
                if (vis) begin
                    left_of[rgt] = lft;
                    right_of[lft] = rgt;
                end
            end
        end
        // colour outward from the centre
        for (x = center - 1; x >= 0; x--)
            vcolor[x] = (right_of[x] == x) ? random_color() : vcolor[right_of[x]];
        for (x = center; x < vw; x++)
            vcolor[x] = (left_of[x] == x) ? random_color() : vcolor[left_of[x]];
    endfunction

    // predict one beat and queue it for the driver
    task automatic send_beat(logic act, logic [7:0] dep, logic last);
        t_in_item  it;
        t_out_item px;
        int w, r, g, b, k;
        it.action = act;
        it.depth = dep;
        it.row_end = last;
        w = width_eff();
        if (act == ACT_LOAD) begin
            if (load_pos < w) begin
                depth_mem[load_pos] = dep;
                load_pos++;
                if (load_pos > written_cnt) written_cnt = load_pos;
            end
            if (last) begin
                link_row(w);
                done_w = w;
                load_pos = 0;
                drain_pos = 0;
                drain_ok = 1;
                odd_row = ~odd_row;
                rows_run++;
            end
        end else if (drain_ok && drain_pos < done_w) begin
            r = 0; g = 0; b = 0;
            for (k = 0; k < OVERSAMPLE; k++) begin
                r += vcolor[drain_pos * OVERSAMPLE + k][23:16];
                g += vcolor[drain_pos * OVERSAMPLE + k][15:8];
                b += vcolor[drain_pos * OVERSAMPLE + k][7:0];
            end
            px.red = 8'(r / OVERSAMPLE);
            px.green = 8'(g / OVERSAMPLE);
            px.blue = 8'(b / OVERSAMPLE);
            px.row_last = (drain_pos + 1 == done_w);
            drain_pos++;
            if (drain_pos >= done_w) drain_ok = 0;
            expected_pixels.push_back(px);
        end
        pending_beats.push_back(it);
        generated++;
    endtask

    function automatic logic [7:0] pick_depth();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom);
    endfunction

    // n loads, row_end on the last one
    task automatic load_row(int n);
        for (int i = 0; i < n; i++) send_beat(ACT_LOAD, pick_depth(), i == n - 1);
    endtask

    task automatic drain_n(int n);
        for (int i = 0; i < n; i++) send_beat(ACT_DRAIN, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // hold off until the block has gone quiet
    task automatic wait_quiet();
        while (pending_beats.size() != 0 || i_in_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ROW_WIDTH: row_width_q = val[10:0];
            CFG_EYE_SEP:   eye_sep_q = val[7:0];
            CFG_STYLE:     style_q = val[1:0];
            CFG_SEED:      lfsr_q = (val == 0) ? 32'd1 : val;
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] w, logic [31:0] eye, logic [31:0] st,
                             logic [31:0] seed);
        write_reg(CFG_ROW_WIDTH, w);
        write_reg(CFG_EYE_SEP, eye);
        write_reg(CFG_STYLE, st);
        write_reg(CFG_SEED, seed);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) accepted <= accepted + 1;
            if (pending_beats.size() != 0 &&
                !(idle_mode == 0 && $urandom_range(0, 99) < 21) &&
                !(idle_mode == 1 && $urandom_range(0, 99) < 45)) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_beats.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            pixels_seen <= pixels_seen + 1;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel %h", o_out_data);
            end else begin
                want = expected_pixels.pop_front();
                if (want.red !== o_out_data.red || want.green !== o_out_data.green ||
                    want.blue !== o_out_data.blue ||
                    want.row_last !== o_out_data.row_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected r%0d g%0d b%0d last%0d, got r%0d g%0d b%0d last%0d",
                                 want.red, want.green, want.blue, want.row_last,
                                 o_out_data.red, o_out_data.green, o_out_data.blue,
                                 o_out_data.row_last);
                end
            end
        end
        i_out_stall <= (idle_mode == 0 && $urandom_range(0, 99) < 45) ||
                       (idle_mode == 1 && $urandom_range(0, 99) < 21);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        idle_mode <= accepted < N_ITEMS / 3 ? 0 : (accepted < 2 * N_ITEMS / 3 ? 1 : 2);
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int w, n, mode;
        row_width_q = 11'd640;
        eye_sep_q = 8'd90;
        style_q = CS_BW;
        lfsr_q = 32'd1;
        odd_row = 0;
        load_pos = 0; drain_pos = 0; done_w = 0; drain_ok = 0; written_cnt = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: drain before any row, narrow row, extremes of width, style and seed, top eye separation
        drain_n(1);
        wait_quiet();
        configure(0, 255, 3, 0);
        load_row(1);
        drain_n(2);
        wait_quiet();
        configure(3, 2, CS_GREY, 32'hFFFF_FFFF);
        load_row(5);           // two samples past the width
        drain_n(4);
        send_beat(ACT_LOAD, 8'd255, 1'b1);   // short row over held depths
        drain_n(3);
        wait_quiet();
        configure(2047, 200, CS_COLOR, 32'h1234_5678);
        load_row(MAX_WIDTH);
        drain_n(40);
        wait_quiet();

        while (generated < N_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
            configure(w, ($urandom_range(0, 5) == 0) ? (($urandom & 1) ? 2 : 255)
                                                   : $urandom_range(2, 255),
                      $urandom_range(0, 3), $urandom);
            repeat ($urandom_range(1, 3)) begin
                w = width_eff();
                if ($urandom_range(0, 7) == 0) drain_n(1);
                mode = $urandom_range(0, 9);
                if (mode == 0 && written_cnt >= w && w > 1) n = $urandom_range(1, w - 1);
                else if (mode == 1) n = w + $urandom_range(1, 3);
                else n = w;
                load_row(n);
                drain_n(($urandom_range(0, 3) == 0) ? $urandom_range(0, w + 2) : w);
            end
            wait_quiet();
        end

        wait_quiet();
        $display("%0d beats accepted, %0d rows processed, %0d pixels checked",
                 accepted, rows_run, pixels_seen);
        $display("widths 1..1024, eye 2..255, all colour styles, short and overlong rows");
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> sirds_scanline_linker.f
+incdir+rtl/core
rtl/core/sirds_pkg.sv
rtl/core/sirds_div.sv
rtl/core/sirds_rng.sv
rtl/core/sirds_scanline_linker.sv
rtl/core/sirds_checker.sv
bench/tb.sv
